// ===== hw/rtl/deadline_timer_queue_top_macros.svh =====
// assertion macros for the deadline timer queue
`ifndef DEADLINE_TIMER_QUEUE_TOP_MACROS_SVH
`define DEADLINE_TIMER_QUEUE_TOP_MACROS_SVH

// same-cycle implication
`define DTQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtq assertion failed");

// next-cycle implication
`define DTQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtq assertion failed");

`endif

// ===== hw/rtl/dtq_pkg.sv =====
// types and constants for the deadline timer queue
package dtq_pkg;

    localparam int ID_BITS     = 31;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_BITS    = $clog2(MAX_RESULTS);

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_AT     = 2'd1;
    localparam logic [1:0] CMD_AFTER  = 2'd2;
    localparam logic [1:0] CMD_CANCEL = 2'd3;

    localparam logic [1:0] KIND_ASSIGNED = 2'd0;
    localparam logic [1:0] KIND_EXPIRED  = 2'd1;
    localparam logic [1:0] KIND_FULL     = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [47:0]        deadline;
        logic signed [31:0] delay_ms;
        logic [30:0]        target_id;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [30:0] entry_id;
        logic        last;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_SUM,
        ST_SCHED,
        ST_SEARCH,
        ST_INSERT,
        ST_CANCEL,
        ST_EXPIRE
    } state_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE,
        OP_POP
    } op_t;

endpackage

// ===== hw/rtl/dtq_cell.sv =====
// one cell of the sorted deadline chain
module dtq_cell #(
    parameter int TIME_BITS = 48
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dtq_pkg::op_t         op,
    input  logic [TIME_BITS-1:0] key_time,
    input  logic [30:0]          key_id,
    input  logic                 prev_valid,
    input  logic                 prev_le,
    input  logic                 prev_hit,
    input  logic [TIME_BITS-1:0] prev_deadline,
    input  logic [30:0]          prev_id,
    input  logic                 next_valid,
    input  logic [TIME_BITS-1:0] next_deadline,
    input  logic [30:0]          next_id,
    output logic                 valid,
    output logic [TIME_BITS-1:0] deadline,
    output logic [30:0]          id,
    output logic                 le,
    output logic                 hit
);
    import dtq_pkg::*;

    logic                 valid_reg, valid_next;
    logic [TIME_BITS-1:0] deadline_reg, deadline_next;
    logic [30:0]          id_reg, id_next;

    assign le  = valid_reg && (deadline_reg <= key_time);
    assign hit = prev_hit || (valid_reg && (id_reg == key_id));

    always_comb
    begin
        valid_next    = valid_reg;
        deadline_next = deadline_reg;
        id_next       = id_reg;
        unique case (op)
            OP_HOLD:
            begin
            end
            OP_INSERT:
            begin
                valid_next = valid_reg || prev_valid;
                if (!le)
                begin
                    if (prev_le)
                    begin
                        deadline_next = key_time;
                        id_next       = key_id;
                    end
                    else
                    begin
                        deadline_next = prev_deadline;
                        id_next       = prev_id;
                    end
                end
            end
            OP_REMOVE:
            begin
                if (hit)
                begin
                    valid_next    = next_valid;
                    deadline_next = next_deadline;
                    id_next       = next_id;
                end
            end
            OP_POP:
            begin
                valid_next    = next_valid;
                deadline_next = next_deadline;
                id_next       = next_id;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        deadline_reg <= deadline_next;
        id_reg       <= id_next;
    end

    assign valid    = valid_reg;
    assign deadline = deadline_reg;
    assign id       = id_reg;

endmodule

// ===== hw/rtl/deadline_timer_queue_top.sv =====
// top level of the deadline timer queue: control sequencer over a chain of cells
// schedule-after scales the delay by 1000 and adds time; a schedule then picks a free id,
// skipping ids in use, and inserts; cancel removes; a tick pops each due entry (at most 16)
// one transaction in flight at a time, set by the identifier search and the expiry loop
// each result is registered and shown for one cycle; the receiver cannot stall
// rst_n clears time, identifier counter and all cell valid bits asynchronously
module deadline_timer_queue_top #(
    parameter int DEPTH     = 16,
    parameter int TIME_BITS = 48
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  dtq_pkg::item_t   item,
    output logic             result_valid,
    output dtq_pkg::result_t result
);
    import dtq_pkg::*;

    localparam int PW = ((TIME_BITS > 41) ? TIME_BITS : 41) + 1;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    state_t               state_reg, state_next;
    item_t                item_reg, item_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [30:0]          last_id_reg, last_id_next;
    logic [TIME_BITS-1:0] when_reg, when_next;
    logic [40:0]          prod_reg, prod_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    result_t              res_reg, res_next;
    logic                 res_valid_reg, res_valid_next;

    op_t                  op;
    logic [TIME_BITS-1:0] key_time;
    logic [30:0]          key_id;
    logic [30:0]          id_inc;
    logic [63:0]          deadline_ext;
    logic [PW-1:0]        sum;
    logic                 last_exp;

    logic                 c_valid [DEPTH];
    logic [TIME_BITS-1:0] c_deadline [DEPTH];
    logic [30:0]          c_id [DEPTH];
    logic                 c_le [DEPTH];
    logic                 c_hit [DEPTH];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            dtq_cell #(.TIME_BITS(TIME_BITS)) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .op            (op),
                .key_time      (key_time),
                .key_id        (key_id),
                .prev_valid    ((g == 0) ? 1'b1 : c_valid[(g == 0) ? 0 : g-1]),
                .prev_le       ((g == 0) ? 1'b1 : c_le[(g == 0) ? 0 : g-1]),
                .prev_hit      ((g == 0) ? 1'b0 : c_hit[(g == 0) ? 0 : g-1]),
                .prev_deadline ((g == 0) ? key_time : c_deadline[(g == 0) ? 0 : g-1]),
                .prev_id       ((g == 0) ? key_id : c_id[(g == 0) ? 0 : g-1]),
                .next_valid    ((g == DEPTH-1) ? 1'b0 : c_valid[(g == DEPTH-1) ? g : g+1]),
                .next_deadline ((g == DEPTH-1) ? '0 : c_deadline[(g == DEPTH-1) ? g : g+1]),
                .next_id       ((g == DEPTH-1) ? '0 : c_id[(g == DEPTH-1) ? g : g+1]),
                .valid         (c_valid[g]),
                .deadline      (c_deadline[g]),
                .id            (c_id[g]),
                .le            (c_le[g]),
                .hit           (c_hit[g])
            );
        end
    endgenerate

    assign id_inc       = ((last_id_reg + 31'd1) == 31'd0) ? 31'd1 : (last_id_reg + 31'd1);
    assign deadline_ext = 64'(item.deadline);
    assign sum          = PW'(now_reg) + PW'(prod_reg);
    assign last_exp     = !c_le[1] || (cnt_reg == CNT_BITS'(MAX_RESULTS - 1));
    assign key_time     = (state_reg == ST_EXPIRE) ? now_reg : when_reg;
    assign key_id       = (state_reg == ST_CANCEL) ? item_reg.target_id : last_id_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (item.cmd)
                        CMD_TICK:   state_next = ST_EXPIRE;
                        CMD_AT:     state_next = ST_SCHED;
                        CMD_AFTER:  state_next = ST_SCALE;
                        CMD_CANCEL: state_next = ST_CANCEL;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCALE:  state_next = ST_SUM;
            ST_SUM:    state_next = ST_SCHED;
            ST_SCHED:  state_next = c_valid[DEPTH-1] ? ST_IDLE : ST_SEARCH;
            ST_SEARCH: state_next = c_hit[DEPTH-1] ? ST_SEARCH : ST_INSERT;
            ST_INSERT: state_next = ST_IDLE;
            ST_CANCEL: state_next = ST_IDLE;
            ST_EXPIRE: state_next = (c_le[0] && !last_exp) ? ST_EXPIRE : ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        item_next      = item_reg;
        now_next       = now_reg;
        last_id_next   = last_id_reg;
        when_next      = when_reg;
        prod_next      = prod_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        res_valid_next = 1'b0;
        op             = OP_HOLD;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next = item;
                    when_next = deadline_ext[TIME_BITS-1:0];
                    cnt_next  = '0;
                    if ((item.cmd == CMD_TICK) && (now_reg != TIME_MAX))
                        now_next = now_reg + TIME_BITS'(1);
                end
            end
            ST_SCALE:
            begin
                prod_next = item_reg.delay_ms[31] ? 41'd0
                          : (41'(item_reg.delay_ms[30:0]) * 41'd1000);
            end
            ST_SUM:
            begin
                when_next = (sum > PW'(TIME_MAX)) ? TIME_MAX : sum[TIME_BITS-1:0];
            end
            ST_SCHED:
            begin
                if (c_valid[DEPTH-1])
                begin
                    res_valid_next = 1'b1;
                    res_next       = '{kind: KIND_FULL, entry_id: 31'd0, last: 1'b1};
                end
                else
                    last_id_next = id_inc;
            end
            ST_SEARCH:
            begin
                if (c_hit[DEPTH-1])
                    last_id_next = id_inc;
            end
            ST_INSERT:
            begin
                op             = OP_INSERT;
                res_valid_next = 1'b1;
                res_next       = '{kind: KIND_ASSIGNED, entry_id: last_id_reg, last: 1'b1};
            end
            ST_CANCEL:
            begin
                op = OP_REMOVE;
            end
            ST_EXPIRE:
            begin
                if (c_le[0])
                begin
                    op             = OP_POP;
                    res_valid_next = 1'b1;
                    res_next       = '{kind: KIND_EXPIRED, entry_id: c_id[0], last: last_exp};
                    cnt_next       = cnt_reg + CNT_BITS'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            now_reg       <= '0;
            last_id_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            last_id_reg   <= last_id_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        when_reg <= when_next;
        prod_reg <= prod_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

`include "deadline_timer_queue_top_macros.svh"

    `DTQ_ASSERT_NOW(a_full_zero_id, result_valid && (result.kind == KIND_FULL), result.entry_id == 31'd0)
    `DTQ_ASSERT_NOW(a_expired_nonzero, result_valid && (result.kind == KIND_EXPIRED), result.entry_id != 31'd0)
    `DTQ_ASSERT_NEXT(a_cancel_silent, start && !busy && (item.cmd == CMD_CANCEL), !result_valid)

endmodule
